// ----- design/lta_pkg.sv -----
// Shared types and constants for the life automaton torus step block.
// No dependencies; imported by lta_row_rule and life_automaton_torus_step.
`timescale 1ns / 1ps

package lta_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int FUNC_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'b1;

  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;
  // unused code: no operation, result is all zero
  localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

  typedef logic [MAX_COLUMNS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_DATA,
    ST_GEN_RD,
    ST_GEN_TAIL,
    ST_GEN_LAST,
    ST_DONE
  } state_t;

endpackage

// ----- design/lta_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/lta_row_rule.sv -----
// Row update unit: applies B3/S23 to one whole row from its three-row window,
// wrapping columns at the active width. Depends on lta_pkg.
`timescale 1ns / 1ps

module lta_row_rule import lta_pkg::*; (
  input  row_t              up,
  input  row_t              mid,
  input  row_t              dn,
  input  logic [SIZE_W-1:0] ncols,
  output row_t              new_row
);

  logic [COL_W-1:0] last;
  row_t up_l, mid_l, dn_l, up_r, mid_r, dn_r;
  logic [3:0] sum;
  logic lb_up, lb_mid, lb_dn, rb_up, rb_mid, rb_dn;

  assign last = COL_W'(ncols - SIZE_W'(1));

  // rotated copies: *_l[c] is column c-1, *_r[c] is column c+1
  assign up_l  = {up[MAX_COLUMNS-2:0],  up[MAX_COLUMNS-1]};
  assign mid_l = {mid[MAX_COLUMNS-2:0], mid[MAX_COLUMNS-1]};
  assign dn_l  = {dn[MAX_COLUMNS-2:0],  dn[MAX_COLUMNS-1]};
  assign up_r  = {up[0],  up[MAX_COLUMNS-1:1]};
  assign mid_r = {mid[0], mid[MAX_COLUMNS-1:1]};
  assign dn_r  = {dn[0],  dn[MAX_COLUMNS-1:1]};

  always_comb begin
    new_row = mid;
    sum = '0;
    lb_up = 1'b0; lb_mid = 1'b0; lb_dn = 1'b0;
    rb_up = 1'b0; rb_mid = 1'b0; rb_dn = 1'b0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      // column 0 wraps left to the last active column, last wraps right to 0
      if (c == 0) begin
        lb_up = up[last]; lb_mid = mid[last]; lb_dn = dn[last];
      end else begin
        lb_up = up_l[c]; lb_mid = mid_l[c]; lb_dn = dn_l[c];
      end
      if (COL_W'(c) == last) begin
        rb_up = up[0]; rb_mid = mid[0]; rb_dn = dn[0];
      end else begin
        rb_up = up_r[c]; rb_mid = mid_r[c]; rb_dn = dn_r[c];
      end
      // nine-cell sum including center: born at 3, survive at 3 or 4
      sum = 4'(lb_up) + 4'(lb_mid) + 4'(lb_dn) + 4'(up[c]) + 4'(mid[c]) + 4'(dn[c])
          + 4'(rb_up) + 4'(rb_mid) + 4'(rb_dn);
      if (c < int'(ncols)) begin
        new_row[c] = (sum == 4'd3) || (mid[c] && (sum == 4'd4));
      end
    end
  end

endmodule

// ----- design/life_automaton_torus_step.sv -----
// Life automaton on a toroidal bit grid (B3/S23), top level with sequencer.
// Depends on lta_pkg, lta_ram and lta_row_rule.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, cell_column, cell_row and
//   cell_value. Func write sets one cell, read returns it on alive_bit, advance
//   steps the whole grid one generation. Each transfer yields exactly one
//   result on the output channel (out_valid/out_ready): alive_bit and
//   range_error. Out-of-range coordinates flag range_error and touch nothing.
//   Grid size comes from cfg_write/cfg_index/cfg_data (columns, rows), to be
//   written only while the block is idle.
//   Flow: cell write/read runs CELL_RD, CELL_DATA, DONE; a bad coordinate or
//   unused code goes to DONE. Advance runs GEN_RD (wrap row, then each row),
//   GEN_TAIL, GEN_LAST: grid memory is read one row per cycle into a
//   three-row window and a single row unit computes and writes back each row.
//   One item is in flight at a time; in_ready is high only while idle, but a
//   new item is taken while the previous result still waits in the output
//   register. A stalled receiver holds the finished item until it is taken.
//   Reset: synchronous; all cells dead (per-row valid flags cleared), size
//   registers return to 64 x 64.
`timescale 1ns / 1ps

module life_automaton_torus_step import lta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    func,
  input  logic [COL_W-1:0]     cell_column,
  input  logic [ROW_W-1:0]     cell_row,
  input  logic                 cell_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 alive_bit,
  output logic                 range_error
);

  state_t state, state_next;

  logic [SIZE_W-1:0] grid_columns, grid_rows;
  logic [SIZE_W-1:0] ncols, nrows;

  logic [FUNC_W-1:0] func_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              val_q;
  logic              res_alive, res_err;

  logic [SIZE_W-1:0] k;
  logic              arr_valid;
  logic [SIZE_W-1:0] arr_k;
  row_t              win_up, win_mid, row0_save;

  logic [MAX_ROWS-1:0] row_valid;
  logic                rd_row_valid;

  logic             ram_wr_en, ram_rd_en;
  logic [ROW_W-1:0] ram_wr_addr, ram_rd_addr, gen_addr;
  row_t             ram_wr_data, ram_rd_data, rd_row, cell_row_mod;
  row_t             rule_dn, rule_row;

  logic in_fire, out_load, coord_bad, cell_op;

  always_comb begin
    ncols = grid_columns;
    if (grid_columns == '0) ncols = SIZE_W'(1);
    else if (grid_columns > SIZE_W'(MAX_COLUMNS)) ncols = SIZE_W'(MAX_COLUMNS);
    nrows = grid_rows;
    if (grid_rows == '0) nrows = SIZE_W'(1);
    else if (grid_rows > SIZE_W'(MAX_ROWS)) nrows = SIZE_W'(MAX_ROWS);
  end

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);
  assign cell_op   = (func == FUNC_WRITE) || (func == FUNC_READ);
  assign coord_bad = (SIZE_W'(cell_column) >= ncols) || (SIZE_W'(cell_row) >= nrows);

  // unwritten rows read as dead
  assign rd_row = rd_row_valid ? ram_rd_data : '0;

  always_comb begin
    cell_row_mod = rd_row;
    cell_row_mod[col_q] = val_q;
  end

  // read order: last row first (upper wrap), then rows 0 .. nrows-1
  assign gen_addr = (k == '0) ? ROW_W'(nrows - SIZE_W'(1)) : ROW_W'(k - SIZE_W'(1));
  assign rule_dn  = (state == ST_GEN_LAST) ? row0_save : rd_row;

  lta_row_rule u_rule (
    .up      (win_up),
    .mid     (win_mid),
    .dn      (rule_dn),
    .ncols   (ncols),
    .new_row (rule_row)
  );

  lta_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (cell_op && !coord_bad) state_next = ST_CELL_RD;
          else if (func == FUNC_ADVANCE) state_next = ST_GEN_RD;
          else state_next = ST_DONE;
        end
      end
      ST_CELL_RD:   state_next = ST_CELL_DATA;
      ST_CELL_DATA: state_next = ST_DONE;
      ST_GEN_RD:    if (k == nrows) state_next = ST_GEN_TAIL;
      ST_GEN_TAIL:  state_next = ST_GEN_LAST;
      ST_GEN_LAST:  state_next = ST_DONE;
      ST_DONE:      if (out_load) state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    ram_rd_en   = (state == ST_CELL_RD) || (state == ST_GEN_RD);
    ram_rd_addr = (state == ST_GEN_RD) ? gen_addr : row_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = row_q;
    ram_wr_data = cell_row_mod;
    priority if (state == ST_CELL_DATA) begin
      ram_wr_en = (func_q == FUNC_WRITE);
    end else if (state == ST_GEN_LAST) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = ROW_W'(nrows - SIZE_W'(1));
      ram_wr_data = rule_row;
    end else if (arr_valid && (arr_k >= SIZE_W'(2))) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = ROW_W'(arr_k - SIZE_W'(2));
      ram_wr_data = rule_row;
    end else begin
      ram_wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      grid_columns <= SIZE_W'(MAX_COLUMNS);
      grid_rows    <= SIZE_W'(MAX_ROWS);
      row_valid    <= '0;
      arr_valid    <= 1'b0;
      out_valid    <= 1'b0;
      k            <= '0;
    end else begin
      state     <= state_next;
      arr_valid <= (state == ST_GEN_RD);
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GRID_COLUMNS: grid_columns <= cfg_data;
          REG_GRID_ROWS:    grid_rows    <= cfg_data;
        endcase
      end
      if (ram_wr_en) row_valid[ram_wr_addr] <= 1'b1;
      if (in_fire) k <= '0;
      else if (state == ST_GEN_RD) k <= k + SIZE_W'(1);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd_en) rd_row_valid <= row_valid[ram_rd_addr];
    arr_k <= k;
    if (in_fire) begin
      func_q    <= func;
      col_q     <= cell_column;
      row_q     <= cell_row;
      val_q     <= cell_value;
      res_alive <= 1'b0;
      res_err   <= cell_op && coord_bad;
    end
    if ((state == ST_CELL_DATA) && (func_q == FUNC_READ)) begin
      res_alive <= rd_row[col_q];
    end
    // sliding three-row window of old rows
    if (arr_valid) begin
      win_up  <= win_mid;
      win_mid <= rd_row;
      if (arr_k == SIZE_W'(1)) row0_save <= rd_row;
    end
    if (out_load) begin
      alive_bit   <= res_alive;
      range_error <= res_err;
    end
  end

endmodule
